[rtl/positional_handle_queue_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the positional handle queue unit.
// Each check is sampled on the rising edge of clk and is held off while
// arst_n is low. Synthesis builds define SYNTH and the checks disappear.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_HANDLE_QUEUE_UNIT_MACROS_SVH
`define POSITIONAL_HANDLE_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define PHQ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional_handle_queue_unit: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PHQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional_handle_queue_unit: next-cycle check failed");

`else

`define PHQ_ASSERT_SAME(lbl, ante, cons)
`define PHQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/phq_pkg.sv]
// ---------------------------------------------------------------------------
// phq_pkg
// Operation codes, status codes and stream layout of the handle queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package phq_pkg;

	// Operation codes carried in the lowest bits of the input transfer.
	typedef enum logic [3:0] {
		OP_APPEND       = 4'd0,
		OP_INSERT_AT    = 4'd1,
		OP_REMOVE_VALUE = 4'd2,
		OP_REMOVE_AT    = 4'd3,
		OP_FIND         = 4'd4,
		OP_READ_AT      = 4'd5,
		OP_TAKE_AT      = 4'd6,
		OP_READ_FIRST   = 4'd7,
		OP_READ_LAST    = 4'd8,
		OP_TAKE_FIRST   = 4'd9
	} op_t;

	// Result status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;
	localparam logic [1:0] STAT_NULL = 2'd3;

	// Field widths fixed by the stream format.
	localparam int OP_W    = 4;
	localparam int POS_W   = 8;
	localparam int HDL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int FPOS_W  = 7;
	localparam int COUNT_W = 7;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 48;

	// Found position reported when a handle is absent.
	localparam logic [FPOS_W-1:0] FPOS_NONE = 7'h7f;

endpackage

`default_nettype wire

[rtl/positional_handle_queue_unit.sv]
// ---------------------------------------------------------------------------
// positional_handle_queue_unit
// Ordered list of nonzero task handles with positional insert and delete.
// ---------------------------------------------------------------------------
// Usage. Each input transfer on the s_axis channel carries one operation: an
// opcode, a signed list position and a handle. Each operation yields exactly
// one result transfer on the m_axis channel with a status, the handle read or
// taken, the position found by a search and the entry count after the
// operation. Results leave in the order the operations arrived.
// The list lives in a single RAM with a registered read. One operation is
// worked on at a time; the input is ready again in the cycle after the
// result has been placed in the output register, even if that result has
// not yet been taken. A refused operation goes straight to the result; an
// append at the tail or a removal of the last entry needs no shift; a read
// passes through the read and fetch states. An insert or remove moves its
// entries one by one through the RAM port, after the read and fetch states
// when the entry is also read. A find or a removal by handle compares the
// entries one by one. The walk through the RAM port therefore sets the
// rate; the worst case is a removal from the head of a full list.
// Reset clears the count and the control state; the RAM itself is not
// cleared, because no entry at or beyond the count is ever read.
// If the receiver stalls, the result waits in the output register; a second
// finished result waits inside the block and the input stays not ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_handle_queue_unit
	import phq_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int HANDLE_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// [3:0] operation, [11:4] position, [43:12] handle, [47:44] zero
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// [1:0] status, [33:2] read_handle, [40:34] found_position,
	// [47:41] entry_count
	output logic      [OUT_W-1:0] m_axis_tdata
);

	`include "positional_handle_queue_unit_macros.svh"

	// Address width of the store, and count width wide enough to hold DEPTH.
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	// Width used to compare a position against the count.
	localparam int PW = (CW > POS_W - 1) ? CW : POS_W - 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SEARCH,
		ST_READ,
		ST_FETCH,
		ST_CLOSE,
		ST_SHIFT,
		ST_DRAIN,
		ST_PUT,
		ST_OUT
	} state_t;

	state_t state_q;

	// Operation held for the duration of its processing.
	op_t                    op_q;
	logic [POS_W-1:0]       pos_q;
	logic [HANDLE_BITS-1:0] hdl_q;

	logic [CW-1:0]          count_q;
	logic [CW-1:0]          cur_q;   // walk pointer, may reach the count
	logic [AW-1:0]          end_q;   // last address read by a shift walk
	logic [AW-1:0]          at_q;    // target entry of the operation
	logic                   up_q;    // shift walk opens a gap (towards the tail)

	// Read pipeline: address issued in the previous cycle and its valid flag.
	logic                   rv_s1;
	logic [AW-1:0]          ra_s1;

	// Result under construction.
	logic [STAT_W-1:0]      res_status_q;
	logic [HDL_W-1:0]       res_rd_q;
	logic [FPOS_W-1:0]      res_fpos_q;

	// Output register.
	logic                   m_valid_q;
	logic [OUT_W-1:0]       m_data_q;
	logic                   out_load;

	// RAM port signals.
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [HANDLE_BITS-1:0] ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [HANDLE_BITS-1:0] ram_rdata;

	phq_ram #(
		.WIDTH (HANDLE_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Decode helpers, valid while the operation is held.
	logic          pos_neg;
	logic [PW-1:0] pos_ext;
	logic [PW-1:0] cnt_ext;
	logic          pos_in_range;
	logic          hdl_null;
	logic          list_full;
	logic          list_empty;
	logic [AW-1:0] last_idx;
	logic [AW-1:0] ins_at;
	logic          search_rd;
	logic          search_hit;
	logic          search_end;

	// Outcome of the decode cycle.
	state_t            dec_state;
	logic [STAT_W-1:0] dec_status;
	logic [FPOS_W-1:0] dec_fpos;
	logic [AW-1:0]     dec_at;
	logic [CW-1:0]     dec_cur;

	assign pos_neg      = pos_q[POS_W-1];
	assign pos_ext      = PW'(pos_q[POS_W-2:0]);
	assign cnt_ext      = PW'(count_q);
	assign pos_in_range = !pos_neg && (pos_ext < cnt_ext);
	assign hdl_null     = (hdl_q == '0);
	assign list_full    = (count_q == CW'(DEPTH));
	assign list_empty   = (count_q == '0);
	assign last_idx     = AW'(count_q - CW'(1));
	// Insert positions beyond the count go to the tail.
	assign ins_at       = (op_q == OP_INSERT_AT && pos_in_range) ?
	                      AW'(pos_q[POS_W-2:0]) : AW'(count_q);

	// The search issues reads while the pointer is inside the list and
	// compares the data returned in the following cycle.
	assign search_rd    = (cur_q < count_q);
	assign search_hit   = rv_s1 && (ram_rdata == hdl_q);
	assign search_end   = rv_s1 && (ra_s1 == last_idx);

	// The decode cycle picks the first state of the operation and settles the
	// result of an operation that is refused outright.
	always_comb begin
		dec_state  = ST_OUT;
		dec_status = STAT_OK;
		dec_fpos   = '0;
		dec_at     = '0;
		dec_cur    = '0;
		case (op_q)
			OP_APPEND, OP_INSERT_AT: begin
				dec_at  = ins_at;
				dec_cur = count_q - CW'(1);
				if (op_q == OP_INSERT_AT && pos_neg) begin
					dec_status = STAT_MISS;
				end else if (hdl_null) begin
					dec_status = STAT_NULL;
				end else if (list_full) begin
					dec_status = STAT_FULL;
				end else if (ins_at == AW'(count_q)) begin
					dec_state = ST_PUT;
				end else begin
					dec_state = ST_SHIFT;
				end
			end
			OP_REMOVE_VALUE, OP_FIND: begin
				if (hdl_null || list_empty) begin
					dec_status = hdl_null ? STAT_NULL : STAT_MISS;
					if (op_q == OP_FIND) begin
						dec_fpos = FPOS_NONE;
					end
				end else begin
					dec_state = ST_SEARCH;
				end
			end
			OP_REMOVE_AT, OP_READ_AT, OP_TAKE_AT: begin
				dec_at = AW'(pos_q[POS_W-2:0]);
				if (!pos_in_range) begin
					dec_status = STAT_MISS;
				end else begin
					dec_state = (op_q == OP_REMOVE_AT) ? ST_CLOSE : ST_READ;
				end
			end
			OP_READ_FIRST, OP_READ_LAST, OP_TAKE_FIRST: begin
				dec_at = (op_q == OP_READ_LAST) ? last_idx : '0;
				if (list_empty) begin
					dec_status = STAT_MISS;
				end else begin
					dec_state = ST_READ;
				end
			end
			default: begin
				dec_status = STAT_MISS;
			end
		endcase
	end

	// RAM port steering. A shift walk writes each entry read in the previous
	// cycle one place further up or down; the read stays ahead of the write,
	// so no entry is overwritten before it has been read.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ra_s1;
		ram_wdata = ram_rdata;
		ram_raddr = cur_q[AW-1:0];
		case (state_q)
			ST_SHIFT, ST_DRAIN: begin
				ram_we    = rv_s1;
				ram_waddr = up_q ? (ra_s1 + AW'(1)) : (ra_s1 - AW'(1));
			end
			ST_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = at_q;
				ram_wdata = hdl_q;
			end
			ST_READ: begin
				ram_raddr = at_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// The finished result moves to the output register once that is free.
	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rv_s1     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			rv_s1 <= (state_q == ST_SHIFT) ||
			         ((state_q == ST_SEARCH) && search_rd && !search_hit && !search_end);

			if (out_load) begin
				m_valid_q <= 1'b1;
				m_data_q  <= {COUNT_W'(count_q), res_fpos_q, res_rd_q, res_status_q};
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= op_t'(s_axis_tdata[OP_W-1:0]);
						pos_q   <= s_axis_tdata[OP_W +: POS_W];
						hdl_q   <= HANDLE_BITS'(s_axis_tdata[OP_W + POS_W +: HDL_W]);
						state_q <= ST_DECODE;
					end
				end

				ST_DECODE: begin
					res_status_q <= dec_status;
					res_rd_q     <= '0;
					res_fpos_q   <= dec_fpos;
					at_q         <= dec_at;
					cur_q        <= dec_cur;
					end_q        <= ins_at;
					up_q         <= 1'b1;
					state_q      <= dec_state;
				end

				ST_SEARCH: begin
					ra_s1 <= cur_q[AW-1:0];
					cur_q <= cur_q + CW'(1);
					if (search_hit) begin
						if (op_q == OP_FIND) begin
							res_fpos_q <= FPOS_W'(ra_s1);
							state_q    <= ST_OUT;
						end else begin
							at_q    <= ra_s1;
							state_q <= ST_CLOSE;
						end
					end else if (search_end) begin
						res_status_q <= STAT_MISS;
						if (op_q == OP_FIND) begin
							res_fpos_q <= FPOS_NONE;
						end
						state_q <= ST_OUT;
					end
				end

				ST_READ: begin
					state_q <= ST_FETCH;
				end

				ST_FETCH: begin
					res_rd_q <= HDL_W'(ram_rdata);
					if (op_q == OP_TAKE_AT || op_q == OP_TAKE_FIRST) begin
						state_q <= ST_CLOSE;
					end else begin
						state_q <= ST_OUT;
					end
				end

				ST_CLOSE: begin
					// Removing the last entry needs no shift.
					if (at_q == last_idx) begin
						count_q <= count_q - CW'(1);
						state_q <= ST_OUT;
					end else begin
						cur_q   <= CW'(at_q) + CW'(1);
						end_q   <= last_idx;
						up_q    <= 1'b0;
						state_q <= ST_SHIFT;
					end
				end

				ST_SHIFT: begin
					ra_s1 <= cur_q[AW-1:0];
					cur_q <= up_q ? (cur_q - CW'(1)) : (cur_q + CW'(1));
					if (cur_q[AW-1:0] == end_q) begin
						state_q <= ST_DRAIN;
					end
				end

				ST_DRAIN: begin
					if (up_q) begin
						state_q <= ST_PUT;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= ST_OUT;
					end
				end

				ST_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_OUT;
				end

				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The count never passes the store depth.
	`PHQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
	// An operation moves the count by at most one entry per cycle.
	`PHQ_ASSERT_NEXT(a_count_step, 1'b1, CW'($past(count_q) - count_q + CW'(1)) <= CW'(2))
	// The store is written only by a shift walk or the final insert write.
	`PHQ_ASSERT_SAME(a_write_state, ram_we, (state_q == ST_SHIFT) || (state_q == ST_DRAIN) || (state_q == ST_PUT))
	// A new result is loaded only from the result state.
	`PHQ_ASSERT_NEXT(a_result_src, !m_valid_q && (state_q != ST_OUT), !m_valid_q)

endmodule

`default_nettype wire

[rtl/phq_ram.sv]
// ---------------------------------------------------------------------------
// phq_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for positional_handle_queue_unit
// Drives list operations over the input stream and checks each result
// transfer, field by field, against a queue-based predictor of the list or the answer a directed row carries.
// ---------------------------------------------------------------------------

module testbench;
	import phq_pkg::*;

	// The list depth that the block is built with here.
	localparam int QDEPTH      = 64;
	// Cycles with no transfer on either side before the run is given up.
	localparam int STALL_LIMIT = 1000;
	// Settling time after the last result: a full-list walk and some margin.
	localparam int DRAIN_WAIT  = QDEPTH + 30;
	localparam int RANDOM_OPS  = 1625;

	// Opcodes the block does not define; each is answered with a miss.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd10;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [HDL_W-1:0]   read_handle;
		logic [FPOS_W-1:0]  found_pos;
		logic [COUNT_W-1:0] entry_count;
	} outcome_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		logic [HDL_W-1:0] hdl;
		logic             typed;
		outcome_t         want;
	} directed_row_t;

	localparam int NUM_DIRECTED = 24;

	// Directed opening sequence. Rows with typed set carry their answer; the
	// others are checked against the predictor.
	directed_row_t directed_rows [NUM_DIRECTED] = '{
		// Empty list reads and takes all miss.
		'{OP_READ_FIRST,   8'd0,   32'h0,        1'b1, '{STAT_MISS, 32'h0, 7'd0, 7'd0}},
		'{OP_READ_LAST,    8'd0,   32'h0,        1'b1, '{STAT_MISS, 32'h0, 7'd0, 7'd0}},
		'{OP_TAKE_FIRST,   8'd0,   32'h0,        1'b1, '{STAT_MISS, 32'h0, 7'd0, 7'd0}},
		// Null handle refusals; a negative insert position wins over null.
		'{OP_APPEND,       8'd0,   32'h0,        1'b1, '{STAT_NULL, 32'h0, 7'd0, 7'd0}},
		'{OP_INSERT_AT,    8'hff,  32'h0,        1'b1, '{STAT_MISS, 32'h0, 7'd0, 7'd0}},
		'{OP_FIND,         8'd0,   32'h0,        1'b1, '{STAT_NULL, 32'h0, FPOS_NONE, 7'd0}},
		'{OP_REMOVE_VALUE, 8'd0,   32'h0,        1'b1, '{STAT_NULL, 32'h0, 7'd0, 7'd0}},
		// Extreme handles, and an insert far past the end landing at the tail.
		'{OP_APPEND,       8'd0,   32'hffffffff, 1'b1, '{STAT_OK,   32'h0, 7'd0, 7'd1}},
		'{OP_APPEND,       8'd0,   32'h00000001, 1'b1, '{STAT_OK,   32'h0, 7'd0, 7'd2}},
		'{OP_INSERT_AT,    8'h7f,  32'h80000000, 1'b1, '{STAT_OK,   32'h0, 7'd0, 7'd3}},
		'{OP_INSERT_AT,    8'd0,   32'h12345678, 1'b0, '0},
		'{OP_READ_LAST,    8'd0,   32'h0,        1'b0, '0},
		'{OP_FIND,         8'd0,   32'h00000001, 1'b0, '0},
		'{OP_FIND,         8'd0,   32'hdeadbeef, 1'b0, '0},
		'{OP_READ_AT,      8'd1,   32'h0,        1'b0, '0},
		'{OP_READ_AT,      8'h80,  32'h0,        1'b0, '0},
		'{OP_REMOVE_AT,    8'd4,   32'h0,        1'b0, '0},
		'{OP_TAKE_AT,      8'd2,   32'h0,        1'b0, '0},
		'{OP_REMOVE_VALUE, 8'd0,   32'hffffffff, 1'b0, '0},
		'{OP_REMOVE_VALUE, 8'd0,   32'h55555555, 1'b0, '0},
		'{OP_SPARE_HI,     8'd0,   32'h0,        1'b0, '0},
		'{OP_TAKE_FIRST,   8'd0,   32'h0,        1'b0, '0},
		'{OP_REMOVE_AT,    8'd0,   32'h0,        1'b0, '0},
		'{OP_READ_FIRST,   8'd0,   32'h0,        1'b1, '{STAT_MISS, 32'h0, 7'd0, 7'd0}}
	};

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	// Mirror of the list contents; its size is the entry count.
	logic [HDL_W-1:0] held_handles [$];
	// Results still owed by the block, oldest first.
	outcome_t         awaited_outcomes [$];

	int mismatch_count;
	int idle_cycles;
	int send_quiet;
	int recv_quiet;
	int results_seen;

	positional_handle_queue_unit #(
		.DEPTH       (QDEPTH),
		.HANDLE_BITS (HDL_W)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Applies one operation to the mirrored list and returns what the block
	// should answer.
	function automatic outcome_t predict_queue_outcome(input logic [OP_W-1:0] op,
			input logic signed [POS_W-1:0] pos, input logic [HDL_W-1:0] hdl);
		outcome_t o;
		int       at;
		int       hit;
		o   = '0;
		hit = -1;
		case (op)
			OP_APPEND, OP_INSERT_AT: begin
				if (op == OP_INSERT_AT && pos < 0)
					o.status = STAT_MISS;
				else if (hdl == '0)
					o.status = STAT_NULL;
				else if (held_handles.size() >= QDEPTH)
					o.status = STAT_FULL;
				else begin
					// Positions beyond the count go to the tail.
					at = held_handles.size();
					if (op == OP_INSERT_AT && int'(pos) < at)
						at = int'(pos);
					held_handles.insert(at, hdl);
				end
			end
			OP_REMOVE_VALUE, OP_FIND: begin
				if (hdl == '0) begin
					o.status = STAT_NULL;
					if (op == OP_FIND)
						o.found_pos = FPOS_NONE;
				end else begin
					for (int i = 0; i < held_handles.size(); i++)
						if (hit < 0 && held_handles[i] == hdl)
							hit = i;
					if (hit < 0)
						o.status = STAT_MISS;
					if (op == OP_FIND)
						o.found_pos = (hit < 0) ? FPOS_NONE : FPOS_W'(hit);
					else if (hit >= 0)
						held_handles.delete(hit);
				end
			end
			OP_REMOVE_AT, OP_READ_AT, OP_TAKE_AT: begin
				if (pos < 0 || int'(pos) >= held_handles.size())
					o.status = STAT_MISS;
				else begin
					at = int'(pos);
					if (op != OP_REMOVE_AT)
						o.read_handle = held_handles[at];
					if (op != OP_READ_AT)
						held_handles.delete(at);
				end
			end
			OP_READ_FIRST, OP_READ_LAST, OP_TAKE_FIRST: begin
				if (held_handles.size() == 0)
					o.status = STAT_MISS;
				else if (op == OP_READ_LAST)
					o.read_handle = held_handles[held_handles.size() - 1];
				else begin
					o.read_handle = held_handles[0];
					if (op == OP_TAKE_FIRST)
						held_handles.delete(0);
				end
			end
			default: begin
				o.status = STAT_MISS;
			end
		endcase
		o.entry_count = COUNT_W'(held_handles.size());
		return o;
	endfunction

	// Wait before the next transfer, drawn at random; now and then a run of
	// back-to-back transfers is started instead.
	function automatic int draw_gap(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	task automatic report_mismatch(input string what, input logic [HDL_W-1:0] seen,
			input logic [HDL_W-1:0] wanted);
		$display("%0t result %0d: %s got 0x%0h, expected 0x%0h",
			$realtime, results_seen, what, seen, wanted);
		mismatch_count++;
	endtask

	// Presents one operation, waits for its transfer and records the answer
	// that is then owed.
	task automatic send_operation(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [HDL_W-1:0] hdl, input logic typed, input outcome_t want);
		int       gap;
		outcome_t predicted;
		gap = draw_gap(send_quiet);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, hdl, pos, op};
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		predicted = predict_queue_outcome(op, $signed(pos), hdl);
		awaited_outcomes.insert(awaited_outcomes.size(), typed ? want : predicted);
	endtask

	// Stimulus: reset, the directed rows, then fill and drain sweeps with
	// random content.
	initial begin
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		logic [HDL_W-1:0] hdl;
		logic             filling;
		int               roll;
		int               fill;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		send_quiet     = 0;
		mismatch_count = 0;
		filling        = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_operation(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].hdl,
				directed_rows[i].typed, directed_rows[i].want);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			fill = held_handles.size();
			// Linger a little at full and at empty so that refusals there get hit.
			if (fill >= QDEPTH && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (fill == 0 && $urandom_range(0, 3) == 0)
				filling = 1'b1;

			if ($urandom_range(0, 9) < 6) begin
				if (filling)
					op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT_AT;
				else begin
					case ($urandom_range(0, 3))
						0:       op = OP_REMOVE_VALUE;
						1:       op = OP_REMOVE_AT;
						2:       op = OP_TAKE_AT;
						default: op = OP_TAKE_FIRST;
					endcase
				end
			end else if ($urandom_range(0, 15) == 0)
				op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			else
				op = OP_W'($urandom_range(0, 15));

			// Handles: null, one already stored, a small value likely to repeat,
			// or anything at all.
			roll = $urandom_range(0, 99);
			if (roll < 8)
				hdl = '0;
			else if (roll < 50 && fill > 0)
				hdl = held_handles[$urandom_range(0, fill - 1)];
			else if (roll < 60)
				hdl = HDL_W'($urandom_range(1, 4));
			else
				hdl = $urandom;

			// Positions: negative, anywhere, exactly the count, or inside the list.
			roll = $urandom_range(0, 99);
			if (roll < 10)
				pos = POS_W'($urandom_range(128, 255));
			else if (roll < 20)
				pos = POS_W'($urandom_range(0, 127));
			else if (roll < 30 || fill == 0)
				pos = POS_W'(fill);
			else
				pos = POS_W'($urandom_range(0, fill - 1));

			send_operation(op, pos, hdl, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;

		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("positional_handle_queue_unit test passed");
		else
			$display("positional_handle_queue_unit test failed");
		$finish;
	end

	// Result side: random back-pressure, then each transfer is compared with
	// the oldest owed answer.
	initial begin
		int       stall;
		outcome_t seen;
		outcome_t wanted;
		m_axis_tready = 1'b0;
		recv_quiet    = 0;
		results_seen  = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = draw_gap(recv_quiet);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do
				@(posedge clk);
			while (!(m_axis_tvalid && m_axis_tready));
			seen.status      = m_axis_tdata[1:0];
			seen.read_handle = m_axis_tdata[33:2];
			seen.found_pos   = m_axis_tdata[40:34];
			seen.entry_count = m_axis_tdata[47:41];
			if (awaited_outcomes.size() == 0)
				report_mismatch("unexpected transfer, read handle", seen.read_handle, '0);
			else begin
				wanted = awaited_outcomes[0];
				awaited_outcomes.delete(0);
				if (seen.status != wanted.status)
					report_mismatch("status", HDL_W'(seen.status), HDL_W'(wanted.status));
				if (seen.read_handle != wanted.read_handle)
					report_mismatch("read handle", seen.read_handle, wanted.read_handle);
				if (seen.found_pos != wanted.found_pos)
					report_mismatch("found position", HDL_W'(seen.found_pos),
						HDL_W'(wanted.found_pos));
				if (seen.entry_count != wanted.entry_count)
					report_mismatch("entry count", HDL_W'(seen.entry_count),
						HDL_W'(wanted.entry_count));
			end
			results_seen++;
		end
	end

	// Watchdog: too long without a transfer on either side means the block
	// has hung or lost an answer.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("positional_handle_queue_unit test failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial idle_cycles = 0;

endmodule
